/* sv/sorted_key_table_search_top_defines.svh */
// Assertion macros for the sorted key table search block.
// Used by the top level only; needs a signal named clk and a signal named rst in scope.
`ifndef SORTED_KEY_TABLE_SEARCH_TOP_DEFINES_SVH
`define SORTED_KEY_TABLE_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sktbl_pkg.sv */
// Shared types and constants for the sorted key table search block.
// No dependencies; used by every module of the block except sktbl_ram.
package sktbl_pkg;

  localparam int KEY_W            = 48;
  localparam int CODE_W           = 16;
  localparam int STATUS_W         = 3;
  localparam int DEF_TABLE_DEPTH  = 512;
  localparam int DEF_CODE_BITS    = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED  = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_FOUND   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef struct packed {
    logic    latch;
    logic    clr;
    logic    ld_rd;
    logic    shift;
    logic    place;
    logic    sr_rd;
    logic    sr_lt;
    logic    sr_gt;
    logic    emit;
    status_t emit_status;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_lookup;
    logic dup;
    logic full;
    logic pos_zero;
    logic rd_gt;
    logic empty;
    logic key_lt;
    logic key_gt;
  } st_t;

endpackage

/* sv/sktbl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sktbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/sktbl_ctrl.sv */
// Controller state machine for the sorted key table search block.
// Depends on sktbl_pkg; drives the datapath through cmd_t and reads st_t.
module sktbl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sktbl_pkg::st_t   st,
  output sktbl_pkg::cmd_t  cmd
);

  import sktbl_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PCHK  = 7'b0000100,
    S_LRD   = 7'b0001000,
    S_LCMP  = 7'b0010000,
    S_SRD   = 7'b0100000,
    S_SCMP  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.emit_status = ST_LOADED;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_PCHK;
        end
      end
      S_PCHK: begin
        priority if (st.is_lookup) begin
          state_next = S_SRD;
        end else if (st.dup) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_DUP;
          state_next      = S_IDLE;
        end else if (st.full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_FULL;
          state_next      = S_IDLE;
        end else begin
          state_next = S_LRD;
        end
      end
      S_LRD: begin
        if (st.pos_zero) begin
          cmd.place       = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_LOADED;
          state_next      = S_IDLE;
        end else begin
          cmd.ld_rd  = 1'b1;
          state_next = S_LCMP;
        end
      end
      S_LCMP: begin
        if (st.rd_gt) begin
          cmd.shift  = 1'b1;
          state_next = S_LRD;
        end else begin
          cmd.place       = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_LOADED;
          state_next      = S_IDLE;
        end
      end
      S_SRD: begin
        if (st.empty) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_MISSING;
          state_next      = S_IDLE;
        end else begin
          cmd.sr_rd  = 1'b1;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        priority if (st.key_lt) begin
          cmd.sr_lt  = 1'b1;
          state_next = S_SRD;
        end else if (st.key_gt) begin
          cmd.sr_gt  = 1'b1;
          state_next = S_SRD;
        end else begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_FOUND;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/sktbl_dp.sv */
// Datapath for the sorted key table search block: entry table, code presence map,
// search bounds and insert pointer. Depends on sktbl_pkg and sktbl_ram.
module sktbl_dp #(
  parameter int TABLE_DEPTH = sktbl_pkg::DEF_TABLE_DEPTH,
  parameter int CODE_BITS   = sktbl_pkg::DEF_CODE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           func,
  input  logic [sktbl_pkg::CODE_W-1:0]   entry_code,
  input  logic [sktbl_pkg::KEY_W-1:0]    acronym_key,
  input  sktbl_pkg::cmd_t                cmd,
  output sktbl_pkg::st_t                 st,
  output logic                           done,
  output logic [sktbl_pkg::STATUS_W-1:0] status,
  output logic [sktbl_pkg::CODE_W-1:0]   found_code
);

  import sktbl_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = KEY_W + CODE_BITS;
  localparam int PRES_DEPTH = 1 << CODE_BITS;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     pos;
  logic [CNT_W-1:0]     lo;
  logic [CNT_W-1:0]     hiex;
  logic [CODE_BITS-1:0] clr_addr;
  logic                 func_q;
  logic [CODE_BITS-1:0] code_q;
  logic [KEY_W-1:0]     key_q;

  logic [CNT_W:0]       mid_sum;
  logic [CNT_W-1:0]     mid;
  logic [CNT_W-1:0]     pos_m1;
  logic [ENT_W-1:0]     ent_rdata;
  logic [ENT_W-1:0]     ent_wdata;
  logic [IDX_W-1:0]     ent_raddr;
  logic [KEY_W-1:0]     rd_key;
  logic [CODE_BITS-1:0] rd_code;
  logic                 pres_rdata;
  logic                 pres_we;
  logic [CODE_BITS-1:0] pres_waddr;

  assign mid_sum   = {1'b0, lo} + {1'b0, hiex} - (CNT_W + 1)'(1);
  assign mid       = mid_sum[CNT_W:1];
  assign pos_m1    = pos - CNT_W'(1);
  assign ent_raddr = cmd.ld_rd ? pos_m1[IDX_W-1:0] : mid[IDX_W-1:0];
  assign ent_wdata = cmd.shift ? ent_rdata : {key_q, code_q};
  assign rd_key    = ent_rdata[ENT_W-1:CODE_BITS];
  assign rd_code   = ent_rdata[CODE_BITS-1:0];

  assign pres_we    = cmd.clr | cmd.place;
  assign pres_waddr = cmd.clr ? clr_addr : code_q;

  sktbl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (cmd.shift | cmd.place),
    .waddr (pos[IDX_W-1:0]),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  sktbl_ram #(
    .WIDTH (1),
    .DEPTH (PRES_DEPTH)
  ) u_pres_ram (
    .clk   (clk),
    .we    (pres_we),
    .waddr (pres_waddr),
    .wdata (cmd.place),
    .raddr (entry_code[CODE_BITS-1:0]),
    .rdata (pres_rdata)
  );

  always_comb begin
    st.clr_last  = &clr_addr;
    st.is_lookup = func_q;
    st.dup       = pres_rdata;
    st.full      = (count == CNT_W'(TABLE_DEPTH));
    st.pos_zero  = (pos == '0);
    st.rd_gt     = (rd_key > key_q);
    st.empty     = (lo >= hiex);
    st.key_lt    = (key_q < rd_key);
    st.key_gt    = (key_q > rd_key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.clr) begin
        clr_addr <= clr_addr + CODE_BITS'(1);
      end
      if (cmd.place) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= func;
      code_q <= entry_code[CODE_BITS-1:0];
      key_q  <= acronym_key;
      pos    <= count;
      lo     <= '0;
      hiex   <= count;
    end
    if (cmd.shift) begin
      pos <= pos_m1;
    end
    if (cmd.sr_lt) begin
      hiex <= mid;
    end
    if (cmd.sr_gt) begin
      lo <= mid + CNT_W'(1);
    end
    if (cmd.emit) begin
      status     <= cmd.emit_status;
      found_code <= (cmd.emit_status == ST_FOUND) ? CODE_W'(rd_code) : '0;
    end
  end

endmodule

/* sv/sorted_key_table_search_top.sv */
// Usage: sorted (key, code) table with load and binary-search lookup.
// Command port: a word (func, entry_code, acronym_key) is taken at a rising edge
//   with start high and busy low. func 0 loads an entry, func 1 looks up a key.
// Result: done is high for exactly one cycle with status and found_code; the
//   receiver cannot stall it, so it must take the word in that cycle.
// Steps from the accepting edge to the done cycle:
//   load rejected (duplicate code or table full): ends after the check state.
//   load accepted: the insert walk reads and shifts up each stored entry whose
//     key is greater than the new key, reading on the entry RAM read port and
//     shifting on its write port, then writes the new entry into the freed slot.
//   lookup: ends at a match or when the search bounds are empty, after P probes,
//     at most ceil(log2(entries+1)); each probe is one registered read.
// busy drops in the cycle done is shown, so the next word can be given there.
// Reset: rst (synchronous) empties the table, then a sweep clears the code
//   presence map, one code per cycle, with busy high until the sweep ends.
// Depends on sktbl_pkg, sktbl_ctrl, sktbl_dp, sktbl_ram and the defines header.
`include "sorted_key_table_search_top_defines.svh"

module sorted_key_table_search_top #(
  parameter int TABLE_DEPTH = sktbl_pkg::DEF_TABLE_DEPTH,
  parameter int CODE_BITS   = sktbl_pkg::DEF_CODE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic [sktbl_pkg::CODE_W-1:0]   entry_code,
  input  logic [sktbl_pkg::KEY_W-1:0]    acronym_key,
  output logic                           done,
  output logic [sktbl_pkg::STATUS_W-1:0] status,
  output logic [sktbl_pkg::CODE_W-1:0]   found_code
);

  import sktbl_pkg::*;

  cmd_t cmd;
  st_t  st;

  sktbl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  sktbl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CODE_BITS   (CODE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .entry_code  (entry_code),
    .acronym_key (acronym_key),
    .cmd         (cmd),
    .st          (st),
    .done        (done),
    .status      (status),
    .found_code  (found_code)
  );

  `SKT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `SKT_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without a word in progress")
  `SKT_ASSERT_NEXT(a_single_done, done, !done, "two results for one word")
  `SKT_ASSERT_NOW(a_found_zero, done && (status != ST_FOUND), found_code == '0, "found_code not zero")

endmodule
